// ----- rtl/core/rzs_pkg.sv -----
// ----------------------------------------------------------------------------
// rzs_pkg
// Shared widths, codes and reset values for the rolling z-score pair signal.
// ----------------------------------------------------------------------------
package rzs_pkg;

  localparam int PRICE_W           = 24;
  localparam int SPREAD_W          = 25;
  localparam int THR_W             = 12;
  localparam int THR_SQ_W          = 2 * THR_W;
  localparam int CNT_W             = 32;
  localparam int NUM_CODES         = 4;
  localparam int DIG_W             = 16;
  localparam int LHS_SHIFT         = 16;
  localparam int CFG_IDX_W         = 4;
  localparam int WINDOW_LENGTH_DEF = 8;

  localparam int IN_DATA_W  = 2 * PRICE_W;
  localparam int OUT_USED_W = 2 + NUM_CODES * CNT_W;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  localparam logic [THR_W-1:0] ENTRY_RESET = 12'd256;
  localparam logic [THR_W-1:0] EXIT_RESET  = 12'd205;

  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_THR = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXIT_THR  = 4'd1;

  typedef enum logic [1:0] {
    SIG_LONG_SHORT = 2'd0,
    SIG_SHORT_LONG = 2'd1,
    SIG_CLOSE      = 2'd2,
    SIG_NONE       = 2'd3
  } sig_code_t;

endpackage

// ----- rtl/core/rolling_zscore_pair_signal_top.sv -----
// ----------------------------------------------------------------------------
// rolling_zscore_pair_signal_top
// Rolling z-score pair signal: spread ring in RAM, exact threshold tests.
// ----------------------------------------------------------------------------
// Filling the window: each item passes through PREP and UPDATE, no result.
// Full window: PREP, then seven ISSUE/WAIT passes through the shared digit-serial
// multiplier, then DECIDE (held until the output slot is free) and UPDATE;
// out_tvalid rises as DECIDE ends. A new item is taken only back in IDLE.
// Synchronous reset clears window sums, fill count, pointer and counters and
// loads thresholds 1.0 and 0.8; the ring RAM is not cleared (read only once full).
module rolling_zscore_pair_signal_top import rzs_pkg::*; #(
  parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // price_a, price_b
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // signal, long_short_count,
                                            // short_long_count, close_count,
                                            // no_signal_count, zero pad
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [THR_W-1:0]      cfg_data
);

  localparam int L      = $clog2(WINDOW_LENGTH);
  localparam int PTR_W  = L;
  localparam int FILL_W = $clog2(WINDOW_LENGTH + 1);
  localparam int SUM_W  = SPREAD_W + L;
  localparam int SQ_W   = 2 * PRICE_W + L;
  localparam int SM_W   = PRICE_W + L;
  localparam int D_W    = SPREAD_W + 1 + L;
  localparam int DM_W   = SPREAD_W + L;
  localparam int DSQ_W  = 2 * DM_W;
  localparam int V_W    = 2 * PRICE_W + 2 * L;
  localparam int CMP_W  = THR_SQ_W + V_W;
  localparam int A_W    = V_W;
  localparam int B_W    = DM_W;
  localparam int P_W    = A_W + B_W;
  localparam int PSQ_W  = 2 * PRICE_W;

  localparam logic signed [D_W-1:0] N_S = D_W'(WINDOW_LENGTH);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_ISSUE, ST_WAIT, ST_DECIDE, ST_UPDATE
  } state_t;

  typedef enum logic [2:0] {
    OP_E2, OP_X2, OP_DSQ, OP_SSQ, OP_NQ, OP_EV, OP_XV
  } op_t;

  state_t                     state_r, state_nxt;
  op_t                        op_r, op_nxt;
  logic [THR_W-1:0]           entry_r, entry_nxt;
  logic [THR_W-1:0]           exit_r, exit_nxt;
  logic signed [SPREAD_W-1:0] s_r, s_nxt;
  logic signed [SPREAD_W-1:0] old_r, old_nxt;
  logic signed [D_W-1:0]      d_r, d_nxt;
  logic [PSQ_W-1:0]           oldsq_r, oldsq_nxt;
  logic [PSQ_W-1:0]           newsq_r, newsq_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SQ_W-1:0]            sumsq_r, sumsq_nxt;
  logic [FILL_W-1:0]          fill_r, fill_nxt;
  logic [PTR_W-1:0]           ptr_r, ptr_nxt;
  logic [THR_SQ_W-1:0]        e2_r, e2_nxt;
  logic [THR_SQ_W-1:0]        x2_r, x2_nxt;
  logic [DSQ_W-1:0]           dsq_r, dsq_nxt;
  logic [V_W-1:0]             ssq_r, ssq_nxt;
  logic [V_W-1:0]             nq_r, nq_nxt;
  logic [CMP_W-1:0]           ev_r, ev_nxt;
  logic [CMP_W-1:0]           xv_r, xv_nxt;
  logic [CNT_W-1:0]           cnt_r [NUM_CODES];
  logic [CNT_W-1:0]           cnt_nxt [NUM_CODES];
  logic                       out_valid_r, out_valid_nxt;
  sig_code_t                  out_sig_r, out_sig_nxt;

  logic                       in_fire, out_fire, cfg_fire, win_full, slot_free;
  logic [PRICE_W-1:0]         price_a, price_b;
  logic signed [SPREAD_W-1:0] spread_in;
  logic [SPREAD_W-1:0]        ram_rd_data;
  logic signed [SPREAD_W-1:0] old_rd;
  logic [PRICE_W-1:0]         s_mag, old_mag;
  logic [DM_W-1:0]            d_mag;
  logic [SM_W-1:0]            sum_mag;
  logic signed [D_W-1:0]      d_calc;
  logic [V_W-1:0]             var_w;
  logic signed [SUM_W-1:0]    old_ext, s_ext;
  logic [A_W-1:0]             mac_a;
  logic [B_W-1:0]             mac_b;
  logic                       mac_start, mac_done;
  logic [P_W-1:0]             mac_prod;
  logic [CMP_W-1:0]           lhs;
  logic                       above_entry, below_exit, d_pos, d_neg;
  sig_code_t                  code;

  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign win_full  = (fill_r == FILL_W'(WINDOW_LENGTH));
  assign slot_free = !out_valid_r || out_tready;

  assign price_a   = in_tdata[PRICE_W-1:0];
  assign price_b   = in_tdata[2*PRICE_W-1:PRICE_W];
  assign spread_in = $signed({1'b0, price_a}) - $signed({1'b0, price_b});

  rzs_ram #(
    .WIDTH (SPREAD_W),
    .DEPTH (WINDOW_LENGTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (state_r == ST_UPDATE),
    .wr_addr (ptr_r),
    .wr_data (s_r),
    .rd_addr (ptr_r),
    .rd_data (ram_rd_data)
  );

  assign old_rd  = ram_rd_data;
  assign s_mag   = s_r[SPREAD_W-1] ? PRICE_W'(-s_r) : PRICE_W'(s_r);
  assign old_mag = old_rd[SPREAD_W-1] ? PRICE_W'(-old_rd) : PRICE_W'(old_rd);
  assign d_calc  = D_W'(s_r) * N_S - D_W'(sum_r);
  assign d_mag   = d_r[D_W-1] ? DM_W'(-d_r) : DM_W'(d_r);
  assign sum_mag = sum_r[SUM_W-1] ? SM_W'(-sum_r) : SM_W'(sum_r);
  assign var_w   = nq_r - ssq_r;
  assign old_ext = SUM_W'(old_r);
  assign s_ext   = SUM_W'(s_r);

  always_comb begin
    case (op_r)
      OP_E2: begin
        mac_a = A_W'(entry_r);
        mac_b = B_W'(entry_r);
      end
      OP_X2: begin
        mac_a = A_W'(exit_r);
        mac_b = B_W'(exit_r);
      end
      OP_DSQ: begin
        mac_a = A_W'(d_mag);
        mac_b = B_W'(d_mag);
      end
      OP_SSQ: begin
        mac_a = A_W'(sum_mag);
        mac_b = B_W'(sum_mag);
      end
      OP_NQ: begin
        mac_a = A_W'(sumsq_r);
        mac_b = B_W'(WINDOW_LENGTH);
      end
      OP_EV: begin
        mac_a = var_w;
        mac_b = B_W'(e2_r);
      end
      OP_XV: begin
        mac_a = var_w;
        mac_b = B_W'(x2_r);
      end
      default: begin
        mac_a = '0;
        mac_b = '0;
      end
    endcase
  end

  assign mac_start = (state_r == ST_ISSUE);

  rzs_mac #(
    .A_W (A_W),
    .B_W (B_W)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mac_start),
    .a       (mac_a),
    .b       (mac_b),
    .done    (mac_done),
    .product (mac_prod)
  );

  // z > E  <=>  D > 0 and 2^16 * D^2 > E^2 * V
  assign lhs         = CMP_W'(dsq_r) << LHS_SHIFT;
  assign above_entry = lhs > ev_r;
  assign below_exit  = xv_r > lhs;
  assign d_neg       = d_r[D_W-1];
  assign d_pos       = !d_r[D_W-1] && (d_r != '0);

  always_comb begin
    if (d_pos && above_entry) begin
      code = SIG_LONG_SHORT;
    end else if (d_neg && above_entry) begin
      code = SIG_SHORT_LONG;
    end else if (below_exit) begin
      code = SIG_CLOSE;
    end else begin
      code = SIG_NONE;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    entry_nxt     = entry_r;
    exit_nxt      = exit_r;
    s_nxt         = s_r;
    old_nxt       = old_r;
    d_nxt         = d_r;
    oldsq_nxt     = oldsq_r;
    newsq_nxt     = newsq_r;
    sum_nxt       = sum_r;
    sumsq_nxt     = sumsq_r;
    fill_nxt      = fill_r;
    ptr_nxt       = ptr_r;
    e2_nxt        = e2_r;
    x2_nxt        = x2_r;
    dsq_nxt       = dsq_r;
    ssq_nxt       = ssq_r;
    nq_nxt        = nq_r;
    ev_nxt        = ev_r;
    xv_nxt        = xv_r;
    cnt_nxt       = cnt_r;
    out_sig_nxt   = out_sig_r;
    out_valid_nxt = out_valid_r;

    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_fire) begin
      if (cfg_index == REG_ENTRY_THR) begin
        entry_nxt = cfg_data;
      end else if (cfg_index == REG_EXIT_THR) begin
        exit_nxt = cfg_data;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          s_nxt     = spread_in;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        old_nxt   = old_rd;
        oldsq_nxt = old_mag * old_mag;
        newsq_nxt = s_mag * s_mag;
        d_nxt     = d_calc;
        if (win_full) begin
          op_nxt    = OP_E2;
          state_nxt = ST_ISSUE;
        end else begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_ISSUE: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (mac_done) begin
          case (op_r)
            OP_E2:   e2_nxt  = mac_prod[THR_SQ_W-1:0];
            OP_X2:   x2_nxt  = mac_prod[THR_SQ_W-1:0];
            OP_DSQ:  dsq_nxt = mac_prod[DSQ_W-1:0];
            OP_SSQ:  ssq_nxt = mac_prod[V_W-1:0];
            OP_NQ:   nq_nxt  = mac_prod[V_W-1:0];
            OP_EV:   ev_nxt  = mac_prod[CMP_W-1:0];
            OP_XV:   xv_nxt  = mac_prod[CMP_W-1:0];
            default: ev_nxt  = ev_r;
          endcase
          if (op_r == OP_XV) begin
            state_nxt = ST_DECIDE;
          end else begin
            op_nxt    = op_t'(op_r + 3'd1);
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_DECIDE: begin
        if (slot_free) begin
          out_sig_nxt   = code;
          out_valid_nxt = 1'b1;
          cnt_nxt[code] = cnt_r[code] + CNT_W'(1);
          state_nxt     = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (win_full) begin
          sum_nxt   = sum_r - old_ext + s_ext;
          sumsq_nxt = sumsq_r - SQ_W'(oldsq_r) + SQ_W'(newsq_r);
        end else begin
          sum_nxt   = sum_r + s_ext;
          sumsq_nxt = sumsq_r + SQ_W'(newsq_r);
          fill_nxt  = fill_r + FILL_W'(1);
        end
        ptr_nxt   = (ptr_r == PTR_W'(WINDOW_LENGTH - 1)) ? '0 : ptr_r + PTR_W'(1);
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_E2;
      entry_r     <= ENTRY_RESET;
      exit_r      <= EXIT_RESET;
      sum_r       <= '0;
      sumsq_r     <= '0;
      fill_r      <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
      out_sig_r   <= SIG_NONE;
      for (int i = 0; i < NUM_CODES; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      entry_r     <= entry_nxt;
      exit_r      <= exit_nxt;
      sum_r       <= sum_nxt;
      sumsq_r     <= sumsq_nxt;
      fill_r      <= fill_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
      out_sig_r   <= out_sig_nxt;
      for (int i = 0; i < NUM_CODES; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
    s_r     <= s_nxt;
    old_r   <= old_nxt;
    d_r     <= d_nxt;
    oldsq_r <= oldsq_nxt;
    newsq_r <= newsq_nxt;
    e2_r    <= e2_nxt;
    x2_r    <= x2_nxt;
    dsq_r   <= dsq_nxt;
    ssq_r   <= ssq_nxt;
    nq_r    <= nq_nxt;
    ev_r    <= ev_nxt;
    xv_r    <= xv_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, cnt_r[3], cnt_r[2], cnt_r[1], cnt_r[0], out_sig_r};

  // variance cannot be negative once the window is full
  a_var_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE) |-> (nq_r >= ssq_r))
    else $error("negative window variance");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW_LENGTH))
    else $error("fill count beyond window length");

  a_mac_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> (state_r == ST_WAIT))
    else $error("multiplier finished outside wait state");

  a_result_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_DECIDE && win_full))
    else $error("result raised without a decision on a full window");

endmodule

// ----- rtl/core/rzs_ram.sv -----
// ----------------------------------------------------------------------------
// rzs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rzs_ram #(
  parameter  int WIDTH  = 25,
  parameter  int DEPTH  = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/rzs_mac.sv -----
// ----------------------------------------------------------------------------
// rzs_mac
// Digit-serial unsigned multiplier: one DIG_W-bit digit of b per cycle,
// most significant digit first, shift-and-accumulate.
// ----------------------------------------------------------------------------
module rzs_mac import rzs_pkg::*; #(
  parameter int A_W = 54,
  parameter int B_W = 28
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               done,
  output logic [A_W+B_W-1:0] product
);

  localparam int NDIG   = (B_W + DIG_W - 1) / DIG_W;
  localparam int BP_W   = NDIG * DIG_W;
  localparam int P_W    = A_W + B_W;
  localparam int DCNT_W = $clog2(NDIG + 1);

  logic [A_W-1:0]       a_r, a_nxt;
  logic [BP_W-1:0]      b_r, b_nxt;
  logic [P_W-1:0]       acc_r, acc_nxt;
  logic [DCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIG_W-1:0]     digit;
  logic [A_W+DIG_W-1:0] part;
  logic [P_W-1:0]       acc_sh;

  assign digit  = b_r[BP_W-1 -: DIG_W];
  assign part   = a_r * digit;
  assign acc_sh = acc_r << DIG_W;

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      acc_nxt = acc_sh + P_W'(part);
      b_nxt   = b_r << DIG_W;
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      a_nxt    = a;
      b_nxt    = BP_W'(b);
      acc_nxt  = '0;
      cnt_nxt  = DCNT_W'(NDIG);
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// ----- tb/sv/rzs_signal_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rzs_signal_checker
// Watches the price, threshold and signal channels of the rolling z-score
// block, keeps its own copy of the spread window and the signal tallies, and
// predicts each signal transfer. Results are compared in order, field by field.
// ----------------------------------------------------------------------------
module rzs_signal_checker import rzs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [THR_W-1:0]      cfg_data,
  output int                    mismatches,
  output int                    reports_due
);

  localparam int N = WINDOW_LENGTH_DEF;

  // same layout as the used bits of out_tdata, signal in the lowest bits
  typedef struct packed {
    logic [NUM_CODES-1:0][CNT_W-1:0] tally;
    sig_code_t                       code;
  } signal_report_t;

  longint           spread_ring [N];
  longint           window_sum;
  longint           square_sum;
  int               fill_level;
  int               oldest_slot;
  logic [CNT_W-1:0] code_tally [NUM_CODES];
  logic [THR_W-1:0] entry_thr;
  logic [THR_W-1:0] exit_thr;
  signal_report_t   report_q [$];

  initial begin
    mismatches  = 0;
    reports_due = 0;
  end

  // exact test of the z-score against the thresholds, no division or root
  function automatic sig_code_t score_spread(input longint s);
    longint     d;
    logic [127:0] dmag, smag, spread_var, lhs, entry_rhs, exit_rhs;
    d          = N * s - window_sum;
    dmag       = 128'(d < 0 ? -d : d);
    smag       = 128'(window_sum < 0 ? -window_sum : window_sum);
    spread_var = 128'(N) * 128'(square_sum) - smag * smag;
    lhs        = (dmag * dmag) << LHS_SHIFT;
    entry_rhs  = spread_var * 128'(entry_thr) * 128'(entry_thr);
    exit_rhs   = spread_var * 128'(exit_thr) * 128'(exit_thr);
    if (d > 0 && lhs > entry_rhs) return SIG_LONG_SHORT;
    if (d < 0 && lhs > entry_rhs) return SIG_SHORT_LONG;
    if (exit_rhs > lhs) return SIG_CLOSE;
    return SIG_NONE;
  endfunction

  always @(posedge clk) begin : watch
    signal_report_t seen, want;
    longint         s;
    sig_code_t      code;
    if (!rst_n) begin
      for (int k = 0; k < N; k++) spread_ring[k] = 0;
      for (int k = 0; k < NUM_CODES; k++) code_tally[k] = '0;
      window_sum  = 0;
      square_sum  = 0;
      fill_level  = 0;
      oldest_slot = 0;
      entry_thr   = ENTRY_RESET;
      exit_thr    = EXIT_RESET;
      report_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen = signal_report_t'(out_tdata[OUT_USED_W-1:0]);
        if (report_q.size() == 0) begin
          $display("%0t: unexpected signal transfer, expected none actual %0d",
                   $time, seen.code);
          mismatches++;
        end else begin
          want = report_q.pop_front();
          if (seen.code !== want.code) begin
            $display("%0t: signal expected %0d actual %0d", $time, want.code, seen.code);
            mismatches++;
          end
          for (int k = 0; k < NUM_CODES; k++) begin
            if (seen.tally[k] !== want.tally[k]) begin
              $display("%0t: tally of code %0d expected %0d actual %0d",
                       $time, k, want.tally[k], seen.tally[k]);
              mismatches++;
            end
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ENTRY_THR) entry_thr = cfg_data;
        else if (cfg_index == REG_EXIT_THR) exit_thr = cfg_data;
      end

      if (in_tvalid && in_tready) begin
        s = longint'(in_tdata[PRICE_W-1:0]) - longint'(in_tdata[IN_DATA_W-1:PRICE_W]);
        if (fill_level >= N) begin
          code = score_spread(s);
          code_tally[code] = code_tally[code] + CNT_W'(1);
          want.code = code;
          for (int k = 0; k < NUM_CODES; k++) want.tally[k] = code_tally[k];
          report_q = {report_q, want};
          window_sum = window_sum - spread_ring[oldest_slot];
          square_sum = square_sum - spread_ring[oldest_slot] * spread_ring[oldest_slot];
        end else begin
          fill_level++;
        end
        spread_ring[oldest_slot] = s;
        window_sum  = window_sum + s;
        square_sum  = square_sum + s * s;
        oldest_slot = (oldest_slot + 1) % N;
      end
    end
    reports_due <= report_q.size();
  end

endmodule

// ----- tb/sv/tb_rolling_zscore_pair_signal_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rolling_zscore_pair_signal_top
// Drives price pairs and threshold writes into the rolling z-score block with
// random gaps and output stalls; a checker module predicts every signal.
// Directed extremes and flat windows first, then random spread walks under
// several threshold settings.
// ----------------------------------------------------------------------------
module tb_rolling_zscore_pair_signal_top import rzs_pkg::*; ();

  localparam int PRICE_MAX      = (1 << PRICE_W) - 1;
  localparam int ITEMS_PER_RUN  = 140;
  localparam int SETTLE_CYCLES  = 48;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_EXIT_THR + CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = {CFG_IDX_W{1'b1}};

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [THR_W-1:0]      cfg_data   = '0;

  int   mismatches;
  int   reports_due;
  int   stall_left    = 0;
  int   quiet_cycles  = 0;
  logic sender_gaps   = 1'b1;
  logic receiver_gaps = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rolling_zscore_pair_signal_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  rzs_signal_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .reports_due (reports_due)
  );

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      stall_left <= receiver_gaps ? pick_gap() : 0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_rolling_zscore_pair_signal_top failed");
      $finish;
    end
  end

  task automatic send_pair(input logic [PRICE_W-1:0] price_a, input logic [PRICE_W-1:0] price_b);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {price_b, price_a};
    do @(posedge clk); while (!in_tready);
  endtask

  // random price pair with the requested spread a - b
  task automatic send_spread(input int spread);
    int low_price;
    if (spread >= 0) begin
      low_price = $urandom_range(0, PRICE_MAX - spread);
      send_pair(PRICE_W'(low_price + spread), PRICE_W'(low_price));
    end else begin
      low_price = $urandom_range(0, PRICE_MAX + spread);
      send_pair(PRICE_W'(low_price), PRICE_W'(low_price - spread));
    end
  endtask

  task automatic wait_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (reports_due != 0);
  endtask

  // block may still be scoring an item that yields nothing, hence the tail
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_thresholds(input logic [THR_W-1:0] entry_level,
                                input logic [THR_W-1:0] exit_level);
    write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
              THR_W'($urandom));
    write_reg(REG_ENTRY_THR, entry_level);
    write_reg(REG_EXIT_THR, exit_level);
    cfg_valid <= 1'b0;
  endtask

  task automatic directed_pairs();
    repeat (8) send_pair(PRICE_W'(PRICE_MAX), '0);
    send_pair(PRICE_W'(PRICE_MAX), '0);          // flat window, zero deviation
    send_pair('0, PRICE_W'(PRICE_MAX));          // flat window, spread drops
    send_pair(24'h800000, 24'h7FFFFF);
    send_pair(24'h555555, 24'hAAAAAA);
    send_pair(24'hAAAAAA, 24'h555555);
    repeat (8) send_pair('0, '0);
    send_pair(PRICE_W'(1), '0);                  // flat window, spread rises
  endtask

  // spread walk around a centre, with jumps, flat runs and raw noise
  task automatic random_walk(input int count);
    int centre, amp, spread, roll;
    centre = 0;
    amp    = 0;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (n == 0 || roll < 3) begin
        centre = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 1 << 24)) - (1 << 23)
                                             : int'($urandom_range(0, 8192)) - 4096;
        amp    = ($urandom_range(0, 5) == 0) ? 0 : 1 << $urandom_range(0, 18);
      end
      if (roll < 5) begin
        send_pair(PRICE_W'($urandom), PRICE_W'($urandom));
      end else begin
        spread = centre + int'($urandom_range(0, 2 * amp)) - amp;
        if (roll < 15)
          spread += ($urandom_range(0, 1) ? 1 : -1) * (amp + 1) * int'($urandom_range(2, 24));
        if (spread > PRICE_MAX) spread = PRICE_MAX;
        if (spread < -PRICE_MAX) spread = -PRICE_MAX;
        send_spread(spread);
      end
      if (roll == 99) wait_results();
    end
  endtask

  initial begin
    logic [THR_W-1:0] entry_level;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    directed_pairs();
    random_walk(ITEMS_PER_RUN);
    settle();

    for (int run = 0; run < 8; run++) begin
      sender_gaps   <= ($urandom_range(0, 3) != 0);
      receiver_gaps <= ($urandom_range(0, 3) != 0);
      entry_level = THR_W'($urandom_range(64, 768));
      case (run)
        0:       set_thresholds('0, '0);
        1:       set_thresholds({THR_W{1'b1}}, {THR_W{1'b1}});
        2:       set_thresholds('0, {THR_W{1'b1}});
        3:       set_thresholds({THR_W{1'b1}}, '0);
        7:       set_thresholds(ENTRY_RESET, EXIT_RESET);
        default: set_thresholds(entry_level, THR_W'($urandom_range(0, entry_level)));
      endcase
      random_walk(ITEMS_PER_RUN);
      settle();
    end

    if (mismatches == 0) begin
      $display("tb_rolling_zscore_pair_signal_top passed");
    end else begin
      $display("tb_rolling_zscore_pair_signal_top failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/rzs_pkg.sv
rtl/core/rzs_ram.sv
rtl/core/rzs_mac.sv
rtl/core/rolling_zscore_pair_signal_top.sv
tb/sv/rzs_signal_checker.sv
tb/sv/tb_rolling_zscore_pair_signal_top.sv
